// ===== design/sfc_pkg.sv =====
// Shared types, widths, register codes and reset values for the sphere frustum culler.
package sfc_pkg;

  localparam int COORD_WIDTH     = 20;
  localparam int COORD_FRAC_BITS = 8;
  localparam int RADIUS_W        = 19;
  localparam int TERM_W          = 16;
  localparam int TERM_FRAC       = 14;
  localparam int DIST_FIELD_W    = 20;

  localparam int PROD_W  = COORD_WIDTH + TERM_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int VIEW_W  = SUM_W - TERM_FRAC + 1;
  localparam int DIST_W  = VIEW_W + 1;
  localparam int PPROD_W = VIEW_W + TERM_W;
  localparam int DOT_W   = PPROD_W + 1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ROT_W       = 3 * TERM_W;
  localparam int OFFSET_W    = 3 * COORD_WIDTH;
  localparam int PLANES_W    = 4 * TERM_W;
  localparam int NEAR_FAR_W  = 2 * DIST_FIELD_W;

  localparam logic [ROT_W-1:0] ROT_X_RESET = ROT_W'(1) << TERM_FRAC;
  localparam logic [ROT_W-1:0] ROT_Y_RESET = ROT_W'(1) << (TERM_W + TERM_FRAC);
  localparam logic [ROT_W-1:0] ROT_Z_RESET = ROT_W'(1) << (2 * TERM_W + TERM_FRAC);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROT_X      = 3'd0,
    REG_ROT_Y      = 3'd1,
    REG_ROT_Z      = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_PLANES_H   = 3'd4,
    REG_PLANES_V   = 3'd5,
    REG_NEAR_FAR   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    REASON_VISIBLE      = 3'd0,
    REASON_BEHIND       = 3'd1,
    REASON_BEYOND_FAR   = 3'd2,
    REASON_BEFORE_NEAR  = 3'd3,
    REASON_OUTSIDE_SIDE = 3'd4
  } reason_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [RADIUS_W-1:0]    radius_t;
  typedef logic signed [TERM_W-1:0]      term_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [VIEW_W-1:0]      view_t;
  typedef logic signed [PPROD_W-1:0]     pprod_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic        [DIST_W-1:0]      dist_t;

endpackage

// ===== design/sfc_sphere_if.sv =====
// Request channel carrying one world-space bounding sphere.
interface sfc_sphere_if;
  logic            valid;
  logic            ready;
  sfc_pkg::coord_t  centre_x;
  sfc_pkg::coord_t  centre_y;
  sfc_pkg::coord_t  centre_z;
  sfc_pkg::radius_t sphere_radius;

  modport source (output valid, output centre_x, output centre_y, output centre_z,
                  output sphere_radius, input ready);
  modport sink   (input valid, input centre_x, input centre_y, input centre_z,
                  input sphere_radius, output ready);
endinterface

// ===== design/sfc_result_if.sv =====
// Result channel carrying the visibility decision and cull reason.
interface sfc_result_if;
  logic             valid;
  logic             ready;
  logic             visible;
  sfc_pkg::reason_t cull_reason;

  modport source (output valid, output visible, output cull_reason, input ready);
  modport sink   (input valid, input visible, input cull_reason, output ready);
endinterface

// ===== design/sphere_frustum_cull.sv =====
// Sphere versus view frustum culler: four-stage pipeline, one request per cycle unless stalled.
// Each sphere centre is rotated and offset into view space, then tested against
// the camera plane, far and near distances and four side planes; the lowest
// failing test is reported as the cull reason. A request passes through four
// register stages from acceptance to its result being presented:
// the 3x3 rotation multiplies, the sum with offset, the plane multiplies with the
// distance compares, and the plane sums with the priority pick in the output
// register. One request is accepted every cycle while the result side takes
// results; a stall fills empty stages first and then holds all stages.
// The user must write configuration registers only while no request is in flight; the block does not enforce this.
module sphere_frustum_cull (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  sfc_sphere_if.sink                      sphere,
  sfc_result_if.source                    result
);

  logic [sfc_pkg::ROT_W-1:0]      rot_row [3];
  logic [sfc_pkg::OFFSET_W-1:0]   view_offset;
  logic [sfc_pkg::PLANES_W-1:0]   planes_h;
  logic [sfc_pkg::PLANES_W-1:0]   planes_v;
  logic [sfc_pkg::NEAR_FAR_W-1:0] near_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0]  <= sfc_pkg::ROT_X_RESET;
      rot_row[1]  <= sfc_pkg::ROT_Y_RESET;
      rot_row[2]  <= sfc_pkg::ROT_Z_RESET;
      view_offset <= '0;
      planes_h    <= '0;
      planes_v    <= '0;
      near_far    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfc_pkg::REG_ROT_X:    rot_row[0]  <= cfg_wdata[sfc_pkg::ROT_W-1:0];
        sfc_pkg::REG_ROT_Y:    rot_row[1]  <= cfg_wdata[sfc_pkg::ROT_W-1:0];
        sfc_pkg::REG_ROT_Z:    rot_row[2]  <= cfg_wdata[sfc_pkg::ROT_W-1:0];
        sfc_pkg::REG_OFFSET:   view_offset <= cfg_wdata[sfc_pkg::OFFSET_W-1:0];
        sfc_pkg::REG_PLANES_H: planes_h    <= cfg_wdata[sfc_pkg::PLANES_W-1:0];
        sfc_pkg::REG_PLANES_V: planes_v    <= cfg_wdata[sfc_pkg::PLANES_W-1:0];
        sfc_pkg::REG_NEAR_FAR: near_far    <= cfg_wdata[sfc_pkg::NEAR_FAR_W-1:0];
        default: ;
      endcase
    end
  end

  logic             v1, v2, v3, out_valid;
  logic             en1, en2, en3, en4;
  logic             out_visible;
  sfc_pkg::reason_t out_reason;

  assign en4 = !out_valid || result.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign sphere.ready = en1;

  // stage 1: rotation products
  sfc_pkg::coord_t  c_in [3];
  sfc_pkg::prod_t   prod_next [3][3];
  sfc_pkg::prod_t   p1_prod [3][3];
  sfc_pkg::radius_t r1;

  assign c_in[0] = sphere.centre_x;
  assign c_in[1] = sphere.centre_y;
  assign c_in[2] = sphere.centre_z;

  always_comb begin
    for (int row = 0; row < 3; row++) begin
      for (int k = 0; k < 3; k++) begin
        prod_next[row][k] = sfc_pkg::term_t'(rot_row[row][k*sfc_pkg::TERM_W +: sfc_pkg::TERM_W])
                            * c_in[k];
      end
    end
  end

  // stage 2: sum, floor to coordinate format, add offset
  sfc_pkg::sum_t    sum_next [3];
  sfc_pkg::view_t   view_next [3];
  sfc_pkg::view_t   v2_view [3];
  sfc_pkg::radius_t r2;

  always_comb begin
    for (int row = 0; row < 3; row++) begin
      sum_next[row] = sfc_pkg::SUM_W'(p1_prod[row][0]) + sfc_pkg::SUM_W'(p1_prod[row][1])
                      + sfc_pkg::SUM_W'(p1_prod[row][2]);
      view_next[row] =
        sfc_pkg::VIEW_W'($signed(sum_next[row][sfc_pkg::SUM_W-1:sfc_pkg::TERM_FRAC]))
        + sfc_pkg::VIEW_W'(sfc_pkg::coord_t'(
            view_offset[row*sfc_pkg::COORD_WIDTH +: sfc_pkg::COORD_WIDTH]));
    end
  end

  // stage 3: plane products and distance tests
  sfc_pkg::view_t   vz;
  sfc_pkg::dist_t   az;
  sfc_pkg::dist_t   near_d, far_d, r_d;
  logic             behind_next, beyond_next, before_next;
  sfc_pkg::view_t   plane_a [4];
  sfc_pkg::term_t   term_a [4];
  sfc_pkg::term_t   term_b [4];
  sfc_pkg::pprod_t  pa_next [4];
  sfc_pkg::pprod_t  pb_next [4];
  sfc_pkg::pprod_t  p3_a [4];
  sfc_pkg::pprod_t  p3_b [4];
  logic             behind3, beyond3, before3;
  sfc_pkg::radius_t r3;

  always_comb begin
    vz     = v2_view[2];
    az     = sfc_pkg::DIST_W'(vz[sfc_pkg::VIEW_W-1] ? -vz : vz);
    near_d = sfc_pkg::DIST_W'(near_far[sfc_pkg::DIST_FIELD_W-1:0]);
    far_d  = sfc_pkg::DIST_W'(near_far[sfc_pkg::NEAR_FAR_W-1:sfc_pkg::DIST_FIELD_W]);
    r_d    = sfc_pkg::DIST_W'(r2);
    behind_next = sfc_pkg::DIST_W'(vz) > $signed(r_d);
    beyond_next = az > far_d + r_d;
    before_next = vz[sfc_pkg::VIEW_W-1] && (near_d > az + r_d);
    for (int j = 0; j < 4; j++) begin
      plane_a[j] = (j < 2) ? v2_view[0] : v2_view[1];
      if (j < 2) begin
        term_a[j] = sfc_pkg::term_t'(planes_h[(2*(j%2))*sfc_pkg::TERM_W +: sfc_pkg::TERM_W]);
        term_b[j] = sfc_pkg::term_t'(planes_h[(2*(j%2)+1)*sfc_pkg::TERM_W +: sfc_pkg::TERM_W]);
      end else begin
        term_a[j] = sfc_pkg::term_t'(planes_v[(2*(j%2))*sfc_pkg::TERM_W +: sfc_pkg::TERM_W]);
        term_b[j] = sfc_pkg::term_t'(planes_v[(2*(j%2)+1)*sfc_pkg::TERM_W +: sfc_pkg::TERM_W]);
      end
      pa_next[j] = sfc_pkg::PPROD_W'(plane_a[j]) * sfc_pkg::PPROD_W'(term_a[j]);
      pb_next[j] = sfc_pkg::PPROD_W'(vz) * sfc_pkg::PPROD_W'(term_b[j]);
    end
  end

  // stage 4: plane sums and reason priority
  sfc_pkg::dot_t    dot [4];
  sfc_pkg::dot_t    lim;
  logic             side_out;
  sfc_pkg::reason_t reason_next;

  always_comb begin
    lim = -$signed(sfc_pkg::DOT_W'({r3, sfc_pkg::TERM_FRAC'(0)}));
    side_out = 1'b0;
    for (int j = 0; j < 4; j++) begin
      dot[j] = sfc_pkg::DOT_W'(p3_a[j]) + sfc_pkg::DOT_W'(p3_b[j]);
      side_out = side_out || (dot[j] < lim);
    end
    priority if (behind3) begin
      reason_next = sfc_pkg::REASON_BEHIND;
    end else if (beyond3) begin
      reason_next = sfc_pkg::REASON_BEYOND_FAR;
    end else if (before3) begin
      reason_next = sfc_pkg::REASON_BEFORE_NEAR;
    end else if (side_out) begin
      reason_next = sfc_pkg::REASON_OUTSIDE_SIDE;
    end else begin
      reason_next = sfc_pkg::REASON_VISIBLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= sphere.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_prod <= prod_next;
      r1      <= sphere.sphere_radius;
    end
    if (en2) begin
      v2_view <= view_next;
      r2      <= r1;
    end
    if (en3) begin
      p3_a    <= pa_next;
      p3_b    <= pb_next;
      behind3 <= behind_next;
      beyond3 <= beyond_next;
      before3 <= before_next;
      r3      <= r2;
    end
    if (en4) begin
      out_visible <= (reason_next == sfc_pkg::REASON_VISIBLE);
      out_reason  <= reason_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.visible     = out_visible;
  assign result.cull_reason = out_reason;

  a_visible_matches_reason: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.visible == (result.cull_reason == sfc_pkg::REASON_VISIBLE)))
    else $error("visible flag disagrees with cull reason");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && result.valid && !result.ready) |-> !sphere.ready)
    else $error("request taken while pipeline full and stalled");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule
